// ----- design/rau_pkg.sv -----
// Package with the types, constants and codes of the rational arithmetic unit.
package rau_pkg;

    localparam int OPERAND_WIDTH_DEF = 32;
    localparam int FIELD_W = 32;
    localparam int MAG_W = 64;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] result_num;
        logic [62:0]        result_den;
        logic [1:0]         status;
    } out_item_t;

    // Job handed from the front part to the back part.
    typedef struct packed {
        logic              zero_den;
        logic              neg;
        logic [MAG_W-1:0]  num_mag;
        logic [MAG_W-1:0]  den_mag;
    } job_t;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_PROD,
        FS_SUM
    } front_state_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_GCD,
        BS_DIVN,
        BS_DIVD,
        BS_DONE
    } back_state_t;

endpackage

// ----- design/rau_front.sv -----
// Front part: decodes operands, forms the exact cross products and their sum.
module rau_front #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  rau_pkg::in_item_t in_data,
    output logic             job_valid,
    input  logic             job_stall,
    output rau_pkg::job_t    job_data
);

    localparam int W = OPERAND_WIDTH;

    rau_pkg::front_state_t state_reg, state_next;
    logic [1:0]            op_reg;
    logic                  an_neg_reg, ad_neg_reg, bn_neg_reg, bd_neg_reg;
    logic [W:0]            an_mag_reg, ad_mag_reg, bn_mag_reg, bd_mag_reg;
    logic                  p1_neg_reg, p2_neg_reg, pd_neg_reg;
    logic [63:0]           p1_reg, p2_reg, pd_reg;
    rau_pkg::job_t         job_reg, job_next;

    function automatic logic [W:0] mag_of(input logic [31:0] raw);
        logic [W-1:0] b;
        logic [W:0]   ext;
        begin
            b = raw[W-1:0];
            ext = {1'b0, b};
            mag_of = b[W-1] ? ((W+1)'(1) << W) - ext : ext;
        end
    endfunction

    logic        x_neg, y_neg, d_neg;
    logic [W:0]  x1, x2, y1, y2, d1, d2;
    logic        bn_eff_neg;
    logic [63:0] s_mag;
    logic        s_neg;
    logic        n1, n2;

    always_comb
    begin
        bn_eff_neg = (op_reg == rau_pkg::OP_SUB) ? ~bn_neg_reg : bn_neg_reg;
        unique case (rau_pkg::op_t'(op_reg))
            rau_pkg::OP_ADD, rau_pkg::OP_SUB:
            begin
                x1 = an_mag_reg; x2 = bd_mag_reg; x_neg = an_neg_reg ^ bd_neg_reg;
                y1 = bn_mag_reg; y2 = ad_mag_reg; y_neg = bn_eff_neg ^ ad_neg_reg;
                d1 = ad_mag_reg; d2 = bd_mag_reg; d_neg = ad_neg_reg ^ bd_neg_reg;
            end
            rau_pkg::OP_MUL:
            begin
                x1 = an_mag_reg; x2 = bn_mag_reg; x_neg = an_neg_reg ^ bn_neg_reg;
                y1 = '0; y2 = '0; y_neg = 1'b0;
                d1 = ad_mag_reg; d2 = bd_mag_reg; d_neg = ad_neg_reg ^ bd_neg_reg;
            end
            default:
            begin
                x1 = an_mag_reg; x2 = bd_mag_reg; x_neg = an_neg_reg ^ bd_neg_reg;
                y1 = '0; y2 = '0; y_neg = 1'b0;
                d1 = ad_mag_reg; d2 = bn_mag_reg; d_neg = ad_neg_reg ^ bn_neg_reg;
            end
        endcase
    end

    always_comb
    begin
        n1 = p1_neg_reg && (p1_reg != '0);
        n2 = p2_neg_reg && (p2_reg != '0);
        if (n1 == n2)
        begin
            s_neg = n1;
            s_mag = p1_reg + p2_reg;
        end
        else if (p1_reg >= p2_reg)
        begin
            s_neg = n1;
            s_mag = p1_reg - p2_reg;
        end
        else
        begin
            s_neg = n2;
            s_mag = p2_reg - p1_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        job_next = job_reg;
        in_stall = 1'b1;
        job_valid = 1'b0;
        unique case (state_reg)
            rau_pkg::FS_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                    state_next = rau_pkg::FS_PROD;
            end
            rau_pkg::FS_PROD:
            begin
                state_next = rau_pkg::FS_SUM;
            end
            default:
            begin
                job_valid = 1'b1;
                job_next.zero_den = (pd_reg == '0);
                job_next.neg = s_neg ^ pd_neg_reg;
                job_next.num_mag = s_mag;
                job_next.den_mag = pd_reg;
                if (!job_stall)
                    state_next = rau_pkg::FS_IDLE;
            end
        endcase
    end

    assign job_data = job_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rau_pkg::FS_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        if (state_reg == rau_pkg::FS_IDLE && in_valid)
        begin
            op_reg     <= in_data.operation;
            an_neg_reg <= in_data.a_num[W-1];
            ad_neg_reg <= in_data.a_den[W-1];
            bn_neg_reg <= in_data.b_num[W-1];
            bd_neg_reg <= in_data.b_den[W-1];
            an_mag_reg <= mag_of(in_data.a_num);
            ad_mag_reg <= mag_of(in_data.a_den);
            bn_mag_reg <= mag_of(in_data.b_num);
            bd_mag_reg <= mag_of(in_data.b_den);
        end
        if (state_reg == rau_pkg::FS_PROD)
        begin
            p1_reg <= 64'(x1 * x2);
            p2_reg <= 64'(y1 * y2);
            pd_reg <= 64'(d1 * d2);
            p1_neg_reg <= x_neg;
            p2_neg_reg <= y_neg;
            pd_neg_reg <= d_neg;
        end
    end

endmodule

// ----- design/rau_queue.sv -----
// Short queue of jobs between the front and back parts.
module rau_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_stall,
    input  rau_pkg::job_t wr_data,
    output logic          rd_valid,
    input  logic          rd_stall,
    output rau_pkg::job_t rd_data
);

    localparam int AW = $clog2(rau_pkg::QUEUE_DEPTH);

    rau_pkg::job_t  mem_reg [rau_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  wp_reg, rp_reg;
    logic [AW:0]    cnt_reg;
    logic           wr_en, rd_en;

    assign wr_stall = (cnt_reg == (AW+1)'(rau_pkg::QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr_en    = wr_valid && !wr_stall;
    assign rd_en    = rd_valid && !rd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= wp_reg + 1'b1;
            if (rd_en)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

endmodule

// ----- design/rau_back.sv -----
// Back part: binary gcd, two restoring divisions and result formatting.
module rau_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_stall,
    input  rau_pkg::job_t      job_data,
    output logic               out_valid,
    input  logic               out_stall,
    output rau_pkg::out_item_t out_data
);

    rau_pkg::back_state_t state_reg, state_next;
    logic [63:0] u_reg, v_reg, nm_reg, dm_reg;
    logic [6:0]  k_reg;
    logic        neg_reg;
    logic        zero_den_reg;
    logic [63:0] q_reg, r_reg, dvd_reg, g_reg;
    logic [6:0]  cnt_reg;
    rau_pkg::out_item_t out_reg;

    logic [64:0] trial;
    logic [63:0] rsh;

    always_comb
    begin
        rsh = {r_reg[62:0], dvd_reg[63]};
        trial = {1'b0, rsh} - {1'b0, g_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        job_stall = 1'b1;
        unique case (state_reg)
            rau_pkg::BS_IDLE:
            begin
                job_stall = 1'b0;
                if (job_valid)
                    state_next = job_data.zero_den ? rau_pkg::BS_DONE : rau_pkg::BS_GCD;
            end
            rau_pkg::BS_GCD:
                if (u_reg == '0 || v_reg == '0 || u_reg == v_reg)
                    state_next = rau_pkg::BS_DIVN;
            rau_pkg::BS_DIVN:
                if (cnt_reg == 7'd64)
                    state_next = rau_pkg::BS_DIVD;
            rau_pkg::BS_DIVD:
                if (cnt_reg == 7'd64)
                    state_next = rau_pkg::BS_DONE;
            default:
                if (!out_valid || !out_stall)
                    state_next = rau_pkg::BS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rau_pkg::BS_IDLE;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == rau_pkg::BS_DONE && (!out_valid || !out_stall))
                out_valid <= 1'b1;
            else if (!out_stall)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            rau_pkg::BS_IDLE:
            begin
                u_reg   <= job_data.num_mag;
                v_reg   <= job_data.den_mag;
                nm_reg  <= job_data.num_mag;
                dm_reg  <= job_data.den_mag;
                neg_reg <= job_data.neg;
                k_reg   <= '0;
                q_reg   <= '0;
                r_reg   <= '0;
                cnt_reg <= '0;
                zero_den_reg <= job_data.zero_den;
            end
            rau_pkg::BS_GCD:
            begin
                if (u_reg == '0 || v_reg == '0 || u_reg == v_reg)
                begin
                    g_reg   <= (u_reg | v_reg) << k_reg[5:0];
                    dvd_reg <= nm_reg;
                    r_reg   <= '0;
                    cnt_reg <= '0;
                end
                else if (!u_reg[0] && !v_reg[0])
                begin
                    u_reg <= u_reg >> 1;
                    v_reg <= v_reg >> 1;
                    k_reg <= k_reg + 1'b1;
                end
                else if (!u_reg[0])
                    u_reg <= u_reg >> 1;
                else if (!v_reg[0])
                    v_reg <= v_reg >> 1;
                else if (u_reg > v_reg)
                    u_reg <= (u_reg - v_reg) >> 1;
                else
                    v_reg <= (v_reg - u_reg) >> 1;
            end
            rau_pkg::BS_DIVN, rau_pkg::BS_DIVD:
            begin
                if (cnt_reg == 7'd64)
                begin
                    if (state_reg == rau_pkg::BS_DIVN)
                        nm_reg <= q_reg;
                    else
                        dm_reg <= q_reg;
                    dvd_reg <= dm_reg;
                    r_reg   <= '0;
                    q_reg   <= '0;
                    cnt_reg <= '0;
                end
                else
                begin
                    dvd_reg <= {dvd_reg[62:0], 1'b0};
                    if (!trial[64] && !r_reg[63])
                    begin
                        r_reg <= trial[63:0];
                        q_reg <= {q_reg[62:0], 1'b1};
                    end
                    else if (r_reg[63])
                    begin
                        r_reg <= rsh - g_reg;
                        q_reg <= {q_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        r_reg <= rsh;
                        q_reg <= {q_reg[62:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            default:
            begin
                if (!out_valid || !out_stall)
                begin
                    if (zero_den_reg)
                    begin
                        out_reg.result_num <= '0;
                        out_reg.result_den <= '0;
                        out_reg.status <= rau_pkg::ST_ZERO_DEN;
                    end
                    else
                    begin
                        neg_reg <= neg_reg && (nm_reg != '0);
                        if ((!(neg_reg && nm_reg != '0) && nm_reg[63]) ||
                            ((neg_reg && nm_reg != '0) && nm_reg > 64'h8000000000000000))
                        begin
                            out_reg.result_num <= '0;
                            out_reg.result_den <= '0;
                            out_reg.status <= rau_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            out_reg.result_num <= (neg_reg && nm_reg != '0) ?
                                                  (~nm_reg + 64'd1) : nm_reg;
                            out_reg.result_den <= dm_reg[62:0];
                            out_reg.status <= rau_pkg::ST_OK;
                        end
                    end
                end
            end
        endcase
    end

    assign out_data = out_reg;

endmodule

// ----- design/rational_arith_unit.sv -----
// Top level of the rational arithmetic unit.
// One item at a time passes through each part: the front forms the exact
// cross products and their sum, and the back then runs a binary gcd of up to
// about 128 steps and two 64-step shift-subtract divisions. An item with a
// zero denominator skips the gcd and both divisions. The gcd loop and the
// divider set the rate; a two-entry queue lets the front take the next item
// while the back works.
module rational_arith_unit #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rau_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output rau_pkg::out_item_t out_data
);

    logic          fq_valid, fq_stall, qb_valid, qb_stall;
    rau_pkg::job_t fq_data, qb_data;

    rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .job_valid(fq_valid), .job_stall(fq_stall), .job_data(fq_data)
    );

    rau_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(fq_valid), .wr_stall(fq_stall), .wr_data(fq_data),
        .rd_valid(qb_valid), .rd_stall(qb_stall), .rd_data(qb_data)
    );

    rau_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(qb_valid), .job_stall(qb_stall), .job_data(qb_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status == rau_pkg::ST_OK ||
                       out_data.status == rau_pkg::ST_ZERO_DEN ||
                       out_data.status == rau_pkg::ST_OVERFLOW))
        else $error("illegal status code");

    a_den_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == rau_pkg::ST_OK) |-> (out_data.result_den != '0))
        else $error("zero denominator with ok status");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status != rau_pkg::ST_OK) |->
        (out_data.result_num == '0 && out_data.result_den == '0))
        else $error("error result not cleared");

endmodule

// ----- sim/tb_rational_arith_unit.sv -----
// Testbench for the rational arithmetic unit: exact fraction arithmetic checked against a predictor.
`timescale 1ns / 100ps

class rational_scoreboard;
    rau_pkg::out_item_t pending_results[$];
    int errors;
    int checked;

    function logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function rau_pkg::out_item_t reduce_fraction(rau_pkg::in_item_t it);
        rau_pkg::out_item_t r;
        logic signed [129:0] an, ad, bn, bd, num, den;
        logic [129:0] nmag, dmag;
        logic [63:0] g, nm, dm;
        logic neg;
        an = it.a_num;
        ad = it.a_den;
        bn = it.b_num;
        bd = it.b_den;
        case (rau_pkg::op_t'(it.operation))
            rau_pkg::OP_ADD:
            begin
                num = an * bd + bn * ad;
                den = ad * bd;
            end
            rau_pkg::OP_SUB:
            begin
                num = an * bd - bn * ad;
                den = ad * bd;
            end
            rau_pkg::OP_MUL:
            begin
                num = an * bn;
                den = ad * bd;
            end
            default:
            begin
                num = an * bd;
                den = ad * bn;
            end
        endcase
        r = '0;
        if (den == 0)
        begin
            r.status = rau_pkg::ST_ZERO_DEN;
            return r;
        end
        nmag = (num < 0) ? -num : num;
        dmag = (den < 0) ? -den : den;
        g = gcd64(nmag[63:0], dmag[63:0]);
        nm = nmag[63:0] / g;
        dm = dmag[63:0] / g;
        neg = ((num < 0) != (den < 0)) && nm != 0;
        if ((!neg && nm > 64'h7fff_ffff_ffff_ffff) || (neg && nm > 64'h8000_0000_0000_0000))
        begin
            r.status = rau_pkg::ST_OVERFLOW;
            return r;
        end
        r.result_num = neg ? -nm : nm;
        r.result_den = dm[62:0];
        r.status = rau_pkg::ST_OK;
        return r;
    endfunction

    function void note_operands(rau_pkg::in_item_t it);
        pending_results.push_back(reduce_fraction(it));
    endfunction

    function void check_result(rau_pkg::out_item_t got);
        rau_pkg::out_item_t want;
        checked++;
        if (pending_results.size() == 0)
        begin
            $display("%0t: unexpected result num=%0d den=%0d status=%0d", $time,
                got.result_num, got.result_den, got.status);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        if (got.result_num !== want.result_num)
        begin
            $display("%0t: result_num expected %0d actual %0d", $time,
                want.result_num, got.result_num);
            errors++;
        end
        if (got.result_den !== want.result_den)
        begin
            $display("%0t: result_den expected %0d actual %0d", $time,
                want.result_den, got.result_den);
            errors++;
        end
        if (got.status !== want.status)
        begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
        end
    endfunction
endclass

module tb_rational_arith_unit;

    localparam int CYCLE_LIMIT = 1400 * 2000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    rau_pkg::in_item_t in_data;
    logic out_valid;
    logic out_stall;
    rau_pkg::out_item_t out_data;

    rational_scoreboard fractions;
    int cycle_count;
    int idle_pct;
    int ops_sent;

    rational_arith_unit u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic logic [31:0] pick_part();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return $urandom_range(0, 1) ? 32'h1 : 32'hffff_ffff;
            4, 5: return $urandom_range(0, 40) - 20;
            6, 7: return $signed($urandom_range(0, 2000)) - 1000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_fraction_op(logic [1:0] op, logic [31:0] an, logic [31:0] ad,
                                    logic [31:0] bn, logic [31:0] bd);
        rau_pkg::in_item_t it;
        it.operation = op;
        it.a_num = an;
        it.a_den = ad;
        it.b_num = bn;
        it.b_den = bd;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (in_stall);
        fractions.note_operands(it);
        ops_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (fractions.pending_results.size() != 0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            fractions.check_result(out_data);
        out_stall <= ($urandom_range(0, 99) < idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int i;
        fractions = new();
        idle_pct = 27;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int op = 0; op < 4; op++)
        begin
            send_fraction_op(2'(op), 1, 2, 1, 3);
            send_fraction_op(2'(op), 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             32'h8000_0000);
            send_fraction_op(2'(op), 32'h7fff_ffff, 1, 32'h8000_0000, 32'hffff_ffff);
            send_fraction_op(2'(op), 0, 5, 0, 7);
            send_fraction_op(2'(op), 3, 0, 2, 5);
        end
        send_fraction_op(rau_pkg::OP_DIV, 4, 6, 0, 9);
        send_fraction_op(rau_pkg::OP_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
        send_fraction_op(rau_pkg::OP_DIV, 32'h8000_0000, 1, 1, 32'h8000_0000);
        send_fraction_op(rau_pkg::OP_DIV, 32'h8000_0000, 1, 1, 32'h7fff_ffff);
        send_fraction_op(rau_pkg::OP_SUB, 6, -4, 6, -4);

        wait_drained();
        for (i = 0; i < 1330; i++)
        begin
            idle_pct = (i >= 500 && i < 700) ? 0 : 27;
            if (i == 900)
                wait_drained();
            send_fraction_op(2'($urandom_range(0, 3)), pick_part(), pick_part(),
                             pick_part(), pick_part());
        end
        wait_drained();
        repeat (300) @(posedge clk);

        $display("Sent %0d fraction operations over all four operations, checked %0d results,",
                 ops_sent, fractions.checked);
        $display("including zero denominators, overflow and extreme operand values.");
        if (fractions.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
